@@ design/reversing_motor_button_controller_defines.svh @@
// ----------------------------------------------------------------------------
// reversing motor button controller assertion macros
// concurrent check helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef REVERSING_MOTOR_BUTTON_CONTROLLER_DEFINES_SVH
`define REVERSING_MOTOR_BUTTON_CONTROLLER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define RMBC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmbc assertion failed");
// next-cycle implication
`define RMBC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmbc assertion failed");
`else
`define RMBC_ASSERT_NOW(name, clk, rst, ante, cons)
`define RMBC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

@@ design/rmbc_pkg.sv @@
// ----------------------------------------------------------------------------
// rmbc_pkg
// shared types, widths and reset values of the reversing motor controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmbc_pkg;

   localparam int COUNT_BITS  = 16;
   localparam int DELAY_BITS  = 16;
   localparam int CUR_BITS    = 10;
   localparam int DUTY_BITS   = 8;
   localparam int CMP_BITS    = (COUNT_BITS > DELAY_BITS) ? COUNT_BITS : DELAY_BITS;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [DELAY_BITS-1:0] DEBOUNCE_RESET  = DELAY_BITS'(50);
   localparam logic [DELAY_BITS-1:0] TIMEOUT_RESET   = DELAY_BITS'(1000);
   localparam logic [DELAY_BITS-1:0] BLANKING_RESET  = DELAY_BITS'(500);
   localparam logic [CUR_BITS-1:0]   THRESHOLD_RESET = CUR_BITS'(20);
   localparam logic [DUTY_BITS-1:0]  DUTY_RESET      = DUTY_BITS'(255);

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_FORWARD     = 3'd1,
      EV_BACKWARD    = 3'd2,
      EV_RELEASE     = 3'd3,
      EV_TIMEOUT     = 3'd4,
      EV_OVERCURRENT = 3'd5
   } rmbc_event_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DEBOUNCE  = 3'd0,
      CSR_TIMEOUT   = 3'd1,
      CSR_BLANKING  = 3'd2,
      CSR_THRESHOLD = 3'd3,
      CSR_PWM_DUTY  = 3'd4
   } rmbc_csr_index_type;

   typedef struct packed {
      logic [DELAY_BITS-1:0] debounce_delay;
      logic [DELAY_BITS-1:0] run_timeout;
      logic [DELAY_BITS-1:0] blanking_time;
      logic [CUR_BITS-1:0]   current_threshold;
      logic [DUTY_BITS-1:0]  pwm_duty;
   } rmbc_cfg_type;

   typedef struct packed {
      logic                  prior_raw;
      logic                  stable_level;
      logic                  prior_stable;
      logic                  dir_flag;
      logic                  motion_flag;
      logic [COUNT_BITS-1:0] settle_count;
      logic [COUNT_BITS-1:0] run_count;
      logic [COUNT_BITS-1:0] blank_count;
      logic                  drive_a;
      logic                  drive_b;
      logic [DUTY_BITS-1:0]  duty_level;
   } rmbc_state_type;

   // field order from the top bit down, so bridge_a lands in bit 0
   typedef struct packed {
      rmbc_event_type       event_code;
      logic                 debounced_button;
      logic                 forward_dir;
      logic                 running;
      logic [DUTY_BITS-1:0] pwm_out;
      logic                 bridge_b;
      logic                 bridge_a;
   } rmbc_result_type;

   function automatic logic [COUNT_BITS-1:0] grow(input logic [COUNT_BITS-1:0] c);
      return (c == {COUNT_BITS{1'b1}}) ? c : c + COUNT_BITS'(1);
   endfunction

   // counter strictly above a delay register, compared at a common width
   function automatic logic expired(input logic [COUNT_BITS-1:0] c,
                                    input logic [DELAY_BITS-1:0] d);
      return CMP_BITS'(c) > CMP_BITS'(d);
   endfunction

endpackage

@@ design/reversing_motor_button_controller.sv @@
// Reversing motor button controller. Each req item is one millisecond tick with the raw
// button level and a motor current sample; each tick yields exactly one rsp item with the
// H-bridge levels, PWM duty, run and direction flags, debounced button and the tick's event.
// A new item can be taken every clock cycle while req_tready is high; its result is written
// into the output register on acceptance, and req_tready stays high while that register is
// empty or being taken. Throughput is one item per cycle while results are taken, set by the
// single state update between the input handshake and the result register. Configuration
// writes via csr_ are always accepted and should be issued only when no item is in flight.
// ----------------------------------------------------------------------------
// reversing_motor_button_controller
// top level: csr registers, tick state, result register and stream handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "reversing_motor_button_controller_defines.svh"

module reversing_motor_button_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   // input items
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [15:0]                          req_tdata,  // button_level, current_sample
   // result items
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // bridge_a, bridge_b, pwm_out, running, forward_dir, debounced_button, event_code
   output logic [15:0]                          rsp_tdata,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rmbc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [rmbc_pkg::DELAY_BITS-1:0]      csr_data
);

   rmbc_pkg::rmbc_cfg_type    cfg_ff, cfg_in;
   rmbc_pkg::rmbc_state_type  state_ff, state_in, state_step;
   rmbc_pkg::rmbc_result_type rsp_data_ff, rsp_data_in;
   rmbc_pkg::rmbc_event_type  step_event;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      req_accept;
   logic                      rsp_accept;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_valid_ff && rsp_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (rmbc_pkg::rmbc_csr_index_type'(csr_index))
            rmbc_pkg::CSR_DEBOUNCE:  cfg_in.debounce_delay = csr_data;
            rmbc_pkg::CSR_TIMEOUT:   cfg_in.run_timeout    = csr_data;
            rmbc_pkg::CSR_BLANKING:  cfg_in.blanking_time  = csr_data;
            rmbc_pkg::CSR_THRESHOLD: begin
               cfg_in.current_threshold = csr_data[rmbc_pkg::CUR_BITS-1:0];
            end
            rmbc_pkg::CSR_PWM_DUTY:  cfg_in.pwm_duty = csr_data[rmbc_pkg::DUTY_BITS-1:0];
            default: ;
         endcase
      end
   end

   rmbc_step u_step (
      .cfg            (cfg_ff),
      .state_now      (state_ff),
      .button_level   (req_tdata[0]),
      .current_sample (req_tdata[rmbc_pkg::CUR_BITS:1]),
      .state_next     (state_step),
      .event_code     (step_event)
   );

   always_comb begin
      state_in     = req_accept ? state_step : state_ff;
      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);

      rsp_data_in                  = rsp_data_ff;
      if (req_accept) begin
         rsp_data_in.bridge_a         = state_step.drive_a;
         rsp_data_in.bridge_b         = state_step.drive_b;
         rsp_data_in.pwm_out          = state_step.duty_level;
         rsp_data_in.running          = state_step.motion_flag;
         rsp_data_in.forward_dir      = state_step.dir_flag;
         rsp_data_in.debounced_button = state_step.stable_level;
         rsp_data_in.event_code       = step_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_delay    <= rmbc_pkg::DEBOUNCE_RESET;
         cfg_ff.run_timeout       <= rmbc_pkg::TIMEOUT_RESET;
         cfg_ff.blanking_time     <= rmbc_pkg::BLANKING_RESET;
         cfg_ff.current_threshold <= rmbc_pkg::THRESHOLD_RESET;
         cfg_ff.pwm_duty          <= rmbc_pkg::DUTY_RESET;
         state_ff.prior_raw       <= 1'b0;
         state_ff.stable_level    <= 1'b0;
         state_ff.prior_stable    <= 1'b0;
         state_ff.dir_flag        <= 1'b1;
         state_ff.motion_flag     <= 1'b0;
         state_ff.settle_count    <= '0;
         state_ff.run_count       <= '0;
         state_ff.blank_count     <= '0;
         state_ff.drive_a         <= 1'b0;
         state_ff.drive_b         <= 1'b0;
         state_ff.duty_level      <= '0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // bridge is driven one way exactly when the motor runs
   `RMBC_ASSERT_NOW(a_bridge_motion, clock, reset, 1'b1,
      (state_ff.motion_flag == (state_ff.drive_a || state_ff.drive_b))
      && !(state_ff.drive_a && state_ff.drive_b))
   // a forward start reports a forward bridge
   `RMBC_ASSERT_NOW(a_forward_event, clock, reset,
      rsp_valid_ff && (rsp_data_ff.event_code == rmbc_pkg::EV_FORWARD),
      rsp_data_ff.bridge_a && !rsp_data_ff.bridge_b && rsp_data_ff.running)
   // every accepted item leaves a result behind
   `RMBC_ASSERT_NEXT(a_item_result, clock, reset, req_accept, rsp_valid_ff)
   // a taken result with nothing new behind it empties the register
   `RMBC_ASSERT_NEXT(a_result_drain, clock, reset, rsp_accept && !req_accept, !rsp_valid_ff)

endmodule

@@ design/rmbc_step.sv @@
// ----------------------------------------------------------------------------
// rmbc_step
// next-state logic for one tick: debounce, bridge control, overcurrent trip
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmbc_step (
   input  rmbc_pkg::rmbc_cfg_type         cfg,
   input  rmbc_pkg::rmbc_state_type       state_now,
   input  logic                           button_level,
   input  logic [rmbc_pkg::CUR_BITS-1:0]  current_sample,
   output rmbc_pkg::rmbc_state_type       state_next,
   output rmbc_pkg::rmbc_event_type       event_code
);

   always_comb begin
      state_next = state_now;
      event_code = rmbc_pkg::EV_NONE;

      state_next.settle_count = rmbc_pkg::grow(state_now.settle_count);
      state_next.run_count    = rmbc_pkg::grow(state_now.run_count);
      state_next.blank_count  = rmbc_pkg::grow(state_now.blank_count);

      if (button_level != state_now.prior_raw) begin
         state_next.settle_count = '0;
      end
      if (rmbc_pkg::expired(state_next.settle_count, cfg.debounce_delay)) begin
         state_next.stable_level = button_level;
      end

      if (state_now.motion_flag) begin
         // release and timeout may both hit, timeout wins the direction
         if (state_now.dir_flag && !state_next.stable_level) begin
            state_next.drive_a     = 1'b0;
            state_next.drive_b     = 1'b0;
            state_next.dir_flag    = 1'b0;
            state_next.motion_flag = 1'b0;
            event_code             = rmbc_pkg::EV_RELEASE;
         end
         if (rmbc_pkg::expired(state_next.run_count, cfg.run_timeout)) begin
            state_next.drive_a     = 1'b0;
            state_next.drive_b     = 1'b0;
            state_next.dir_flag    = 1'b1;
            state_next.motion_flag = 1'b0;
            event_code             = rmbc_pkg::EV_TIMEOUT;
         end
      end else if (state_now.dir_flag) begin
         if (state_next.stable_level != state_now.prior_stable) begin
            state_next.run_count   = '0;
            state_next.blank_count = '0;
            if (state_next.stable_level) begin
               state_next.drive_a     = 1'b1;
               state_next.drive_b     = 1'b0;
               state_next.duty_level  = cfg.pwm_duty;
               state_next.motion_flag = 1'b1;
               event_code             = rmbc_pkg::EV_FORWARD;
            end else begin
               // arm reverse, it starts on the next tick
               state_next.dir_flag = 1'b0;
            end
         end
      end else begin
         state_next.run_count   = '0;
         state_next.blank_count = '0;
         state_next.drive_a     = 1'b0;
         state_next.drive_b     = 1'b1;
         state_next.duty_level  = cfg.pwm_duty;
         state_next.motion_flag = 1'b1;
         event_code             = rmbc_pkg::EV_BACKWARD;
      end

      // checked whether running or not
      if ((current_sample > cfg.current_threshold)
          && rmbc_pkg::expired(state_next.blank_count, cfg.blanking_time)) begin
         state_next.dir_flag    = ~state_next.dir_flag;
         state_next.drive_a     = 1'b0;
         state_next.drive_b     = 1'b0;
         state_next.motion_flag = 1'b0;
         event_code             = rmbc_pkg::EV_OVERCURRENT;
      end

      state_next.prior_raw    = button_level;
      state_next.prior_stable = state_next.stable_level;
   end

endmodule
